### hw/rtl/mpfb_pkg.sv
// Shared types and codes for the register-mapped pixel framebuffer.
`default_nettype none
package mpfb_pkg;

    localparam int PROD_W = 19;

    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [1:0]        t_cfg_idx;
    typedef logic [15:0]       t_cfg_data;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_SCAN  = 2'd2;

    localparam logic [4:0] OFF_WIDTH  = 5'h00;
    localparam logic [4:0] OFF_HEIGHT = 5'h04;
    localparam logic [4:0] OFF_PITCH  = 5'h08;
    localparam logic [4:0] OFF_ENABLE = 5'h0C;
    localparam logic [4:0] OFF_FLUSH  = 5'h10;
    localparam logic [4:0] OFF_COORD  = 5'h14;
    localparam logic [4:0] OFF_COLOUR = 5'h18;
    localparam logic [4:0] OFF_FILL   = 5'h1C;

    localparam t_cfg_idx CFG_WIDTH  = 2'd0;
    localparam t_cfg_idx CFG_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_PITCH  = 2'd2;

    localparam logic [9:0]  RST_WIDTH  = 10'd640;
    localparam logic [8:0]  RST_HEIGHT = 9'd480;
    localparam logic [15:0] RST_PITCH  = 16'd2560;

    localparam logic [15:0] COORD_MASK = 16'hFFFF;
    localparam logic [7:0]  FILL_ALPHA = 8'hFF;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  reg_offset;
        logic [31:0] write_value;
        logic [18:0] pixel_index;
    } t_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        frame_dirty;
    } t_result;

    typedef enum logic [2:0] {
        K_NOP,
        K_READ,
        K_REGWR,
        K_COLOUR,
        K_FILL,
        K_SCAN
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_PIXW,
        S_FILL,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic exec;
        logic pix_write;
        logic fill_step;
        logic clr_step;
        logic scan_cap;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  cnt_done;
    } t_sts;

endpackage
`default_nettype wire

### hw/rtl/mmio_pixel_framebuffer.sv
// Top level of the register-mapped pixel framebuffer.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------
//  item in  | start, busy           | i_item (mode, offset, data, index)
//  result   | o_strobe (one cycle)  | o_result (read_data, frame_dirty)
//  config   | i_cfg_we, i_cfg_idx   | i_cfg_data
//
// Register reads, register writes and idle codes pass S_EXEC and S_RESP before the next
// accept; colour writes and scan-out reads add S_PIXW or S_SCAN (multiplier stage or store
// read latency). A fill adds S_FILL: one store write per cycle through the sweep counter,
// width*height words. After reset the store is cleared one word a cycle, with busy high
// until it is done; configuration writes are taken meanwhile.
// The result is shown for one cycle on o_strobe; the receiver cannot stall it.
`default_nettype none
module mmio_pixel_framebuffer #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire mpfb_pkg::t_item     i_item,
    input  wire logic                i_cfg_we,
    input  wire mpfb_pkg::t_cfg_idx  i_cfg_idx,
    input  wire mpfb_pkg::t_cfg_data i_cfg_data,
    output logic                     o_strobe,
    output mpfb_pkg::t_result        o_result
);
    import mpfb_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic accept;

    assign accept = start && !busy;

    mpfb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_sts    (sts),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd)
    );

    mpfb_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_result   (o_result)
    );

endmodule
`default_nettype wire

### hw/rtl/mpfb_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module mpfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hw/rtl/mpfb_ctrl.sv
// Controller state machine of the framebuffer.
`default_nettype none
module mpfb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire mpfb_pkg::t_sts i_sts,
    output logic               o_busy,
    output logic               o_strobe,
    output mpfb_pkg::t_cmd     o_cmd
);
    import mpfb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.cnt_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_sts.kind)
                    K_COLOUR: n_state = S_PIXW;
                    K_FILL:   n_state = S_FILL;
                    K_SCAN:   n_state = S_SCAN;
                    default:  n_state = S_RESP;
                endcase
            end
            S_PIXW: n_state = S_RESP;
            S_FILL: begin
                if (i_sts.cnt_done) n_state = S_RESP;
            end
            S_SCAN: n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd    = '0;
        o_busy   = 1'b1;
        o_strobe = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step  = 1'b1;
            S_IDLE:  o_busy          = 1'b0;
            S_EXEC:  o_cmd.exec      = 1'b1;
            S_PIXW:  o_cmd.pix_write = 1'b1;
            S_FILL:  o_cmd.fill_step = 1'b1;
            S_SCAN:  o_cmd.scan_cap  = 1'b1;
            S_RESP:  o_strobe        = 1'b1;
            default: o_busy          = 1'b1;
        endcase
    end

`ifndef SYNTHESIS
    a_resp_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |=> (r_state == S_IDLE))
        else $error("result strobe lasted more than one cycle");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    a_fill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && i_sts.cnt_done) |=> o_strobe)
        else $error("fill finished without a result");
`endif

endmodule
`default_nettype wire

### hw/rtl/mpfb_dp.sv
// Datapath of the framebuffer: registers, address multiplier, sweep counter, pixel store.
`default_nettype none
module mpfb_dp #(
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire mpfb_pkg::t_item    i_item,
    input  wire logic               i_cfg_we,
    input  wire mpfb_pkg::t_cfg_idx i_cfg_idx,
    input  wire mpfb_pkg::t_cfg_data i_cfg_data,
    input  wire mpfb_pkg::t_cmd     i_cmd,
    output mpfb_pkg::t_sts          o_sts,
    output mpfb_pkg::t_result       o_result
);
    import mpfb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    logic [9:0]    r_frame_width;
    logic [8:0]    r_frame_height;
    logic [15:0]   r_line_pitch;
    logic [15:0]   r_x;
    logic [15:0]   r_y;
    logic          r_enable;
    logic          r_dirty;
    logic [CW-1:0] r_cnt;

    t_item         r_item;
    t_prod         r_prod;
    logic          r_inb;
    logic          r_scan_ok;
    logic [31:0]   r_rd;

    t_kind         kind;
    logic [9:0]    eff_w;
    logic [8:0]    eff_h;
    logic [8:0]    mul_b;
    logic          in_bounds;
    logic          scan_ok;
    logic [31:0]   reg_rd;
    logic [CW-1:0] limit;
    logic          cnt_done;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_q;

    assign eff_w = (int'(r_frame_width) > MAX_WIDTH) ? 10'(MAX_WIDTH) : r_frame_width;
    assign eff_h = (int'(r_frame_height) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : r_frame_height;

    assign in_bounds = (r_x < {6'b0, eff_w}) && (r_y < {7'b0, eff_h});
    assign scan_ok   = 32'(r_item.pixel_index) < DEPTH;
    assign mul_b     = (kind == K_COLOUR) ? r_y[8:0] : eff_h;

    always_comb begin
        unique case (r_item.mode)
            MODE_READ:  kind = K_READ;
            MODE_WRITE: begin
                unique case (r_item.reg_offset)
                    OFF_COLOUR: kind = K_COLOUR;
                    OFF_FILL:   kind = K_FILL;
                    default:    kind = K_REGWR;
                endcase
            end
            MODE_SCAN:  kind = K_SCAN;
            default:    kind = K_NOP;
        endcase
    end

    always_comb begin
        unique case (r_item.reg_offset)
            OFF_WIDTH:  reg_rd = {22'b0, r_frame_width};
            OFF_HEIGHT: reg_rd = {23'b0, r_frame_height};
            OFF_PITCH:  reg_rd = {16'b0, r_line_pitch};
            OFF_ENABLE: reg_rd = {31'b0, r_enable};
            default:    reg_rd = '0;
        endcase
    end

    assign limit    = i_cmd.clr_step ? CW'(DEPTH) : CW'(r_prod);
    assign cnt_done = r_cnt >= limit;

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = AW'(r_item.pixel_index);
        ram_wdata = '0;
        if (i_cmd.clr_step || i_cmd.fill_step) begin
            ram_we    = !cnt_done;
            ram_addr  = r_cnt[AW-1:0];
            ram_wdata = i_cmd.fill_step ? {FILL_ALPHA, r_item.write_value[23:0]} : '0;
        end else if (i_cmd.pix_write) begin
            ram_we    = r_inb;
            ram_addr  = AW'(r_prod + t_prod'(r_x[9:0]));
            ram_wdata = r_item.write_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_WIDTH;
            r_frame_height <= RST_HEIGHT;
            r_line_pitch   <= RST_PITCH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_frame_width  <= i_cfg_data[9:0];
                CFG_HEIGHT: r_frame_height <= i_cfg_data[8:0];
                CFG_PITCH:  r_line_pitch   <= i_cfg_data;
                default:    r_line_pitch   <= r_line_pitch;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x      <= '0;
            r_y      <= '0;
            r_enable <= 1'b0;
            r_dirty  <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.exec) begin
                r_cnt <= '0;
                unique case (kind)
                    K_REGWR: begin
                        unique case (r_item.reg_offset)
                            OFF_ENABLE: r_enable <= |r_item.write_value;
                            OFF_FLUSH:  r_dirty  <= 1'b1;
                            OFF_COORD: begin
                                r_x <= r_item.write_value[31:16] & COORD_MASK;
                                r_y <= r_item.write_value[15:0] & COORD_MASK;
                            end
                            default: r_enable <= r_enable;
                        endcase
                    end
                    K_COLOUR: begin
                        if (in_bounds) r_dirty <= 1'b1;
                    end
                    K_FILL: r_dirty <= 1'b1;
                    default: r_dirty <= r_dirty;
                endcase
            end else if ((i_cmd.clr_step || i_cmd.fill_step) && !cnt_done) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
        if (i_cmd.exec) begin
            r_prod    <= t_prod'(eff_w) * t_prod'(mul_b);
            r_inb     <= in_bounds;
            r_scan_ok <= scan_ok;
            r_rd      <= (kind == K_READ) ? reg_rd : '0;
        end else if (i_cmd.scan_cap) begin
            r_rd <= r_scan_ok ? ram_q : '0;
        end
    end

    mpfb_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    assign o_sts.kind     = kind;
    assign o_sts.cnt_done = cnt_done;

    assign o_result.read_data   = r_rd;
    assign o_result.frame_dirty = r_dirty;

`ifndef SYNTHESIS
    a_dirty_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dirty |=> r_dirty)
        else $error("dirty flag cleared");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cnt) <= DEPTH)
        else $error("sweep counter beyond store depth");

    a_wr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (int'(ram_addr) < DEPTH))
        else $error("store write outside depth");
`endif

endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the register-mapped pixel framebuffer.
module tb;
    import mpfb_pkg::*;

    localparam int FB_MAX_W = 640;
    localparam int FB_MAX_H = 480;
    localparam int STORE_WORDS = FB_MAX_W * FB_MAX_H;
    localparam int TIMEOUT_CYCLES = 10_000_000;
    localparam logic [1:0] MODE_NONE = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_item     i_item = '0;
    logic      i_cfg_we = 1'b0;
    t_cfg_idx  i_cfg_idx = CFG_WIDTH;
    t_cfg_data i_cfg_data = '0;
    logic      o_strobe;
    t_result   o_result;

    mmio_pixel_framebuffer #(
        .MAX_WIDTH (FB_MAX_W),
        .MAX_HEIGHT(FB_MAX_H)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    always #6 i_clk = ~i_clk;

    logic [31:0] shadow_pixels [STORE_WORDS];
    logic [15:0] shadow_x;
    logic [15:0] shadow_y;
    logic        shadow_enabled;
    logic        shadow_dirty;
    logic [9:0]  shadow_width;
    logic [8:0]  shadow_height;
    logic [15:0] shadow_pitch;

    t_item   pending_items [$];
    t_result result_due [$];
    int      accept_cnt = 0;
    int      issued_cnt = 0;
    int      results_seen = 0;
    int      items_queued = 0;
    int      fills_queued = 0;
    int      geometries = 0;
    int      mismatches = 0;
    int      gap_left = 0;
    int      calm_left = 0;

    function automatic int unsigned eff_w();
        return (shadow_width > FB_MAX_W) ? FB_MAX_W : shadow_width;
    endfunction

    function automatic int unsigned eff_h();
        return (shadow_height > FB_MAX_H) ? FB_MAX_H : shadow_height;
    endfunction

    function automatic t_result frame_access(input t_item it);
        t_result     r;
        int unsigned w;
        int unsigned h;
        r.read_data = '0;
        w = eff_w();
        h = eff_h();
        case (it.mode)
            MODE_READ: begin
                case (it.reg_offset)
                    OFF_WIDTH:  r.read_data = 32'(shadow_width);
                    OFF_HEIGHT: r.read_data = 32'(shadow_height);
                    OFF_PITCH:  r.read_data = 32'(shadow_pitch);
                    OFF_ENABLE: r.read_data = {31'd0, shadow_enabled};
                    default: ;
                endcase
            end
            MODE_WRITE: begin
                case (it.reg_offset)
                    OFF_ENABLE: shadow_enabled = (it.write_value != 32'd0);
                    OFF_FLUSH:  shadow_dirty = 1'b1;
                    OFF_COORD: begin
                        shadow_x = it.write_value[31:16];
                        shadow_y = it.write_value[15:0];
                    end
                    OFF_COLOUR: begin
                        if (shadow_x < w && shadow_y < h) begin
                            shadow_pixels[shadow_y * w + shadow_x] = it.write_value;
                            shadow_dirty = 1'b1;
                        end
                    end
                    OFF_FILL: begin
                        for (int i = 0; i < w * h; i++)
                            shadow_pixels[i] = {FILL_ALPHA, it.write_value[23:0]};
                        shadow_dirty = 1'b1;
                    end
                    default: ;
                endcase
            end
            MODE_SCAN: begin
                if (it.pixel_index < STORE_WORDS)
                    r.read_data = shadow_pixels[it.pixel_index];
            end
            default: ;
        endcase
        r.frame_dirty = shadow_dirty;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at result %0d, %s: got %h want %h", results_seen, what, got, want);
        mismatches++;
    endtask

    function automatic logic [18:0] any_index();
        return 19'($urandom);
    endfunction

    function automatic logic [4:0] any_offset();
        return 5'($urandom);
    endfunction

    function automatic logic [4:0] pick_reg();
        case ($urandom_range(0, 7))
            0: return OFF_WIDTH;
            1: return OFF_HEIGHT;
            2: return OFF_PITCH;
            3: return OFF_ENABLE;
            4: return OFF_FLUSH;
            5: return OFF_COORD;
            6: return OFF_COLOUR;
            default: return OFF_FILL;
        endcase
    endfunction

    task automatic enqueue_access(input logic [1:0] mode, input logic [4:0] off,
                                  input logic [31:0] val, input logic [18:0] idx);
        t_item it;
        it.mode = mode;
        it.reg_offset = off;
        it.write_value = val;
        it.pixel_index = idx;
        pending_items.push_back(it);
        items_queued++;
        if (mode == MODE_WRITE && off == OFF_FILL)
            fills_queued++;
    endtask

    task automatic queue_random(input int count);
        int          n;
        int          pick;
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        n = 0;
        w = eff_w();
        h = eff_h();
        while (n < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                x = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hFFFF)
                                                : $urandom_range(0, w + 1);
                y = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hFFFF)
                                                : $urandom_range(0, h + 1);
                enqueue_access(MODE_WRITE, OFF_COORD, {x[15:0], y[15:0]}, any_index());
                enqueue_access(MODE_WRITE, OFF_COLOUR, $urandom, any_index());
                enqueue_access(MODE_SCAN, any_offset(), $urandom, 19'(y * w + x));
                n += 3;
            end else if (pick < 55) begin
                enqueue_access(MODE_SCAN, any_offset(), $urandom,
                               ($urandom_range(0, 4) == 0) ? any_index()
                                                           : 19'($urandom_range(0, w * h + 3)));
                n++;
            end else if (pick < 70) begin
                enqueue_access(MODE_READ,
                               ($urandom_range(0, 4) == 0) ? any_offset() : pick_reg(),
                               $urandom, any_index());
                n++;
            end else if (pick < 75) begin
                enqueue_access(MODE_WRITE, OFF_FILL, $urandom, any_index());
                n++;
            end else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0: enqueue_access(MODE_WRITE, OFF_ENABLE,
                                      $urandom_range(0, 1) ? 32'($urandom) : 32'd0,
                                      any_index());
                    1: enqueue_access(MODE_WRITE, OFF_FLUSH, $urandom, any_index());
                    2: enqueue_access(MODE_WRITE, any_offset(), $urandom, any_index());
                    default: enqueue_access(MODE_WRITE, pick_reg(), $urandom, any_index());
                endcase
                n++;
            end else if (pick < 93) begin
                enqueue_access(MODE_NONE, any_offset(), $urandom, any_index());
                n++;
            end else begin
                enqueue_access(2'($urandom), any_offset(), $urandom, any_index());
                n++;
            end
        end
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || accept_cnt != issued_cnt ||
               result_due.size() != 0 || busy !== 1'b0);
    endtask

    task automatic set_frame(input int w, input int h, input int p);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_WIDTH;
        i_cfg_data <= t_cfg_data'(w);
        @(negedge i_clk);
        i_cfg_idx <= CFG_HEIGHT;
        i_cfg_data <= t_cfg_data'(h);
        @(negedge i_clk);
        i_cfg_idx <= CFG_PITCH;
        i_cfg_data <= t_cfg_data'(p);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_width = w[9:0];
        shadow_height = h[8:0];
        shadow_pitch = p[15:0];
        geometries++;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && accept_cnt != issued_cnt)) begin
            if (start) begin
                if (calm_left != 0) begin
                    calm_left--;
                    gap_left = 0;
                end else begin
                    gap_left = $urandom_range(0, 4);
                    if ($urandom_range(0, 31) == 0)
                        calm_left = $urandom_range(10, 40);
                end
            end
            if (gap_left == 0 && pending_items.size() != 0) begin
                i_item <= pending_items.pop_front();
                start <= 1'b1;
                issued_cnt++;
            end else begin
                start <= 1'b0;
                if (gap_left != 0)
                    gap_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (result_due.size() == 0) begin
                    flag_mismatch("result with none due", o_result.read_data, '0);
                end else begin
                    want = result_due.pop_front();
                    results_seen++;
                    if (o_result.read_data !== want.read_data)
                        flag_mismatch("read_data", o_result.read_data, want.read_data);
                    if (o_result.frame_dirty !== want.frame_dirty)
                        flag_mismatch("frame_dirty", 32'(o_result.frame_dirty),
                                      32'(want.frame_dirty));
                end
            end
            if (start && !busy) begin
                result_due.push_back(frame_access(i_item));
                accept_cnt++;
            end
        end
    end

    initial begin
        #(TIMEOUT_CYCLES * 12);
        $display("timeout with %0d results due", result_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int w;
        int h;
        int p;
        foreach (shadow_pixels[k])
            shadow_pixels[k] = '0;
        shadow_x = '0;
        shadow_y = '0;
        shadow_enabled = 1'b0;
        shadow_dirty = 1'b0;
        shadow_width = RST_WIDTH;
        shadow_height = RST_HEIGHT;
        shadow_pitch = RST_PITCH;
        geometries = 1;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        enqueue_access(MODE_READ, OFF_WIDTH, 32'hFFFF_FFFF, 19'h7FFFF);
        enqueue_access(MODE_READ, OFF_HEIGHT, 32'd0, 19'd0);
        enqueue_access(MODE_READ, OFF_PITCH, $urandom, any_index());
        enqueue_access(MODE_READ, OFF_ENABLE, $urandom, any_index());
        enqueue_access(MODE_READ, OFF_COLOUR, $urandom, any_index());
        enqueue_access(MODE_NONE, 5'h1F, 32'hFFFF_FFFF, 19'h7FFFF);
        enqueue_access(MODE_SCAN, 5'h1F, 32'd0, 19'(STORE_WORDS));
        enqueue_access(MODE_SCAN, 5'h00, 32'd0, 19'h7FFFF);
        enqueue_access(MODE_WRITE, OFF_ENABLE, 32'h8000_0000, 19'd0);
        enqueue_access(MODE_READ, OFF_ENABLE, 32'd0, 19'd0);
        enqueue_access(MODE_WRITE, OFF_PITCH, 32'hFFFF_FFFF, 19'd0);
        enqueue_access(MODE_WRITE, OFF_COORD, {16'd640, 16'd0}, 19'd0);
        enqueue_access(MODE_WRITE, OFF_COLOUR, 32'hDEAD_BEEF, 19'd0);
        enqueue_access(MODE_WRITE, OFF_COORD, {16'd639, 16'd479}, 19'd0);
        enqueue_access(MODE_WRITE, OFF_COLOUR, 32'h1122_3344, 19'd0);
        enqueue_access(MODE_SCAN, 5'h00, 32'd0, 19'(STORE_WORDS - 1));
        enqueue_access(MODE_READ, OFF_PITCH, 32'd0, 19'd0);

        drain();
        set_frame(1023, 511, 65535);
        enqueue_access(MODE_READ, OFF_WIDTH, 32'd0, 19'd0);
        enqueue_access(MODE_READ, OFF_HEIGHT, 32'd0, 19'd0);
        enqueue_access(MODE_READ, OFF_PITCH, 32'd0, 19'd0);
        enqueue_access(MODE_WRITE, OFF_FILL, 32'h1234_5678, 19'd0);
        enqueue_access(MODE_SCAN, 5'h00, 32'd0, 19'd0);
        enqueue_access(MODE_SCAN, 5'h00, 32'd0, 19'(STORE_WORDS - 1));

        drain();
        set_frame(0, 0, 0);
        enqueue_access(MODE_WRITE, OFF_FILL, 32'd0, 19'd0);
        enqueue_access(MODE_WRITE, OFF_COORD, 32'd0, 19'd0);
        enqueue_access(MODE_WRITE, OFF_COLOUR, 32'hCAFE_F00D, 19'd0);
        enqueue_access(MODE_SCAN, 5'h00, 32'd0, 19'd0);

        for (int ph = 0; ph < 13; ph++) begin
            case ($urandom_range(0, 9))
                0: begin
                    w = $urandom_range(640, 1023);
                    h = 1;
                end
                1: begin
                    w = 1;
                    h = $urandom_range(480, 511);
                end
                2: begin
                    w = $urandom_range(0, 3);
                    h = $urandom_range(0, 3);
                end
                default: begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 12);
                end
            endcase
            p = $urandom_range(0, 65535);
            drain();
            set_frame(w, h, p);
            queue_random(102);
        end

        drain();
        repeat (16) @(negedge i_clk);
        $display("covered %0d items (%0d fills) over %0d frame geometries",
                 items_queued, fills_queued, geometries);
        $display("checked %0d results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
